// ===== sv/sem_pkg.sv =====
// Shared types, register codes and arithmetic helpers of the Sobel edge magnitude unit.
// Depends on nothing. Every other file of the block but sem_ram imports it.
package sem_pkg;

  localparam int PIX_W  = 24;   // one RGB pixel, red in the top byte
  localparam int CH_W   = 8;    // one color sample
  localparam int GW     = 11;   // signed gradient, spans -1020..1020
  localparam int CFG_DW = 13;   // widest configuration register
  localparam int FW_W   = 11;   // frame_width register
  localparam int FH_W   = 13;   // frame_height register
  localparam int QDEPTH = 4;    // gradient queue entries
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;
  localparam logic [GW-1:0]   MAG_MAX  = 11'd255;

  // Configuration register indexes.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // One classified pixel slot, handed from the front to the window stage.
  typedef struct packed {
    logic [PIX_W-1:0] sample;
    logic             top_en;
    logic             mid_en;
    logic             col0;
    logic             emit;
    logic             last;
  } fe_item_t;

  // Gradients of one result, queued between the window stage and the back end.
  typedef struct packed {
    logic signed [GW-1:0] gx_red;
    logic signed [GW-1:0] gy_red;
    logic signed [GW-1:0] gx_green;
    logic signed [GW-1:0] gy_green;
    logic signed [GW-1:0] gx_blue;
    logic signed [GW-1:0] gy_blue;
    logic                 last;
  } grad_t;

  // Horizontal gradient: right column minus left column, middle row doubled.
  function automatic logic signed [GW-1:0] grad_x(input logic [8:0][CH_W-1:0] p);
    logic [GW-1:0] pos;
    logic [GW-1:0] neg;
    pos = GW'(p[2]) + (GW'(p[5]) << 1) + GW'(p[8]);
    neg = GW'(p[0]) + (GW'(p[3]) << 1) + GW'(p[6]);
    return $signed(pos - neg);
  endfunction

  // Vertical gradient: bottom row minus top row, middle column doubled.
  function automatic logic signed [GW-1:0] grad_y(input logic [8:0][CH_W-1:0] p);
    logic [GW-1:0] pos;
    logic [GW-1:0] neg;
    pos = GW'(p[6]) + (GW'(p[7]) << 1) + GW'(p[8]);
    neg = GW'(p[0]) + (GW'(p[1]) << 1) + GW'(p[2]);
    return $signed(pos - neg);
  endfunction

  // (|gx| + |gy|) / 2, saturated to one byte.
  function automatic logic [CH_W-1:0] half_mag(input logic signed [GW-1:0] gx,
                                               input logic signed [GW-1:0] gy);
    logic [GW-1:0] ax;
    logic [GW-1:0] ay;
    logic [GW-1:0] s;
    logic [GW-1:0] half;
    ax   = gx[GW-1] ? GW'(-gx) : GW'(gx);
    ay   = gy[GW-1] ? GW'(-gy) : GW'(gy);
    s    = ax + ay;
    half = s >> 1;
    return (half > MAG_MAX) ? MAG_MAX[CH_W-1:0] : half[CH_W-1:0];
  endfunction

endpackage

// ===== sv/sobel_edge_magnitude_3x3_unit.sv =====
// 3x3 Sobel edge magnitude on a raster RGB stream: top level with configuration registers.
// Depends on sem_pkg, sem_ram, sem_front, sem_window, sem_queue and sem_back.
//
// Usage. Pixels enter on the in_ channel in raster order (in_cmd low); after the last
// pixel of a frame the source sends frame_width+1 flush words (in_cmd high). Each word
// from the second row's second pixel on completes the window of an earlier pixel, and that
// pixel's result leaves on the out_ channel; the last flush yields the frame's last pixel
// with out_frame_end high. A flush word while pixels are still due is taken and dropped;
// a pixel word where flushes are due acts as a flush.
// Throughput is one word per clock unless out_ready stalls it: the line store is one RAM
// with one read and one write port, read at the column of the word being accepted and
// written when the window stage takes it. A result passes the stage register, the queue
// and the output register. cfg_ writes set frame_width (index 0) and frame_height
// (index 1); cfg_ready is always high, and writes are to be made by the user only while
// the block is idle; the block does not enforce it. Reset restores 640 x 480 and starts
// a new frame; the line store is not cleared, since rows above the image are masked.
// When the receiver holds out_ready low the output register and the gradient queue fill
// and in_ready falls; nothing is lost, and flow resumes at full rate once it releases.
module sobel_edge_magnitude_3x3_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [sem_pkg::CH_W-1:0]    in_red_in,
  input  logic [sem_pkg::CH_W-1:0]    in_green_in,
  input  logic [sem_pkg::CH_W-1:0]    in_blue_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sem_pkg::CH_W-1:0]    out_red_out,
  output logic [sem_pkg::CH_W-1:0]    out_green_out,
  output logic [sem_pkg::CH_W-1:0]    out_blue_out,
  output logic                        out_frame_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [sem_pkg::CFG_DW-1:0]  cfg_data
);
  import sem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  // Front to window stage.
  logic            rd_en;
  logic [CW-1:0]   rd_addr;
  logic            s1_valid;
  fe_item_t        s1_item;
  logic [CW-1:0]   s1_addr;
  logic            s1_take;

  // Line store: each word holds the row above (upper half) and two rows above.
  logic                ram_we;
  logic [CW-1:0]       ram_waddr;
  logic [2*PIX_W-1:0]  ram_wdata;
  logic [2*PIX_W-1:0]  ram_q;

  // Gradient queue.
  logic   q_push, q_ready, q_head_valid, q_pop;
  grad_t  q_data, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
      endcase
    end
  end

  sem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_pixel     ({in_red_in, in_green_in, in_blue_in}),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item),
    .s1_addr      (s1_addr),
    .s1_take      (s1_take)
  );

  sem_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  sem_window #(
    .CW (CW)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_addr   (s1_addr),
    .s1_take   (s1_take),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .ram_q     (ram_q),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  sem_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_data  (q_data),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .head       (q_head)
  );

  sem_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red_out),
    .out_green  (out_green_out),
    .out_blue   (out_blue_out),
    .out_last   (out_frame_end)
  );

endmodule

// ===== sv/sem_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; read during a write to the same address returns the old data.
module sem_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sem_front.sv =====
// Front end: input handshake, raster position tracking, item classification and line read.
// Depends on sem_pkg; feeds sem_window through a one-slot stage register.
module sem_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int WEW = CW + 1,
  localparam int HEW = $clog2(MAX_HEIGHT + 1),
  localparam int RW  = $clog2(MAX_HEIGHT + 3)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [sem_pkg::PIX_W-1:0]  in_pixel,
  input  logic [sem_pkg::FW_W-1:0]   frame_width,
  input  logic [sem_pkg::FH_W-1:0]   frame_height,
  output logic                       rd_en,
  output logic [CW-1:0]              rd_addr,
  output logic                       s1_valid,
  output sem_pkg::fe_item_t          s1_item,
  output logic [CW-1:0]              s1_addr,
  input  logic                       s1_take
);
  import sem_pkg::*;

  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic           s1_valid_r, s1_valid_nxt;
  fe_item_t       s1_item_r;
  logic [CW-1:0]  s1_addr_r;

  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic [RW-1:0]  hr, h1;
  logic [CW-1:0]  col_a, c;
  logic [RW-1:0]  row_a, r;
  logic [WEW-1:0] c_inc;
  logic           pix, drop, accept, load;
  fe_item_t       item;

  // Effective frame size, clamped to the supported range.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WEW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HEW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(frame_height);
    end
    hr = RW'(h_eff);
    h1 = hr + RW'(1);
  end

  // Current position, repaired if the frame size changed under it.
  always_comb begin
    if ({1'b0, col_r} >= w_eff) begin
      col_a = '0;
      row_a = row_r + RW'(1);
    end else begin
      col_a = col_r;
      row_a = row_r;
    end
    if (row_a > h1 || (row_a == h1 && col_a != '0)) begin
      r = '0;
      c = '0;
    end else begin
      r = row_a;
      c = col_a;
    end
  end

  // Classification of the item at this position.
  always_comb begin
    pix         = r < hr;
    drop        = pix && in_cmd;
    item.sample = pix ? in_pixel : '0;
    item.top_en = r >= RW'(2);
    item.mid_en = (r != '0) && (r <= hr);
    item.col0   = c == '0;
    item.emit   = (r >= RW'(2)) || (r == RW'(1) && c != '0);
    item.last   = r == h1;
    c_inc       = {1'b0, c} + WEW'(1);
  end

  assign in_ready = !s1_valid_r || s1_take;
  assign accept   = in_valid && in_ready;
  assign load     = accept && !drop;
  assign rd_en    = load;
  assign rd_addr  = c;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (drop) begin
        col_nxt = c;
        row_nxt = r;
      end else if (item.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (c_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = r + RW'(1);
      end else begin
        col_nxt = c_inc[CW-1:0];
        row_nxt = r;
      end
    end
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= item;
      s1_addr_r <= c;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;
  assign s1_addr  = s1_addr_r;

endmodule

// ===== sv/sem_window.sv =====
// Window stage: 3x3 window shift, line store update with read bypass, gradient sums.
// Depends on sem_pkg; sits between sem_front and the gradient queue.
module sem_window #(
  parameter int CW = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  sem_pkg::fe_item_t           s1_item,
  input  logic [CW-1:0]               s1_addr,
  output logic                        s1_take,
  input  logic                        rd_en,
  input  logic [CW-1:0]               rd_addr,
  input  logic [2*sem_pkg::PIX_W-1:0] ram_q,
  output logic                        ram_we,
  output logic [CW-1:0]               ram_waddr,
  output logic [2*sem_pkg::PIX_W-1:0] ram_wdata,
  input  logic                        q_ready,
  output logic                        q_push,
  output sem_pkg::grad_t              q_data
);
  import sem_pkg::*;

  logic [8:0][PIX_W-1:0]  win_r, win_nxt;
  logic [8:0][PIX_W-1:0]  calc;
  logic                   fwd_hit_r;
  logic [2*PIX_W-1:0]     fwd_data_r;
  logic [2*PIX_W-1:0]     line;
  logic [PIX_W-1:0]       near_raw, far_raw, top, mid;
  logic [8:0][CH_W-1:0]   pr, pg, pb;

  // A read issued in the same cycle as a write to that column sees the old
  // contents, so the written word is kept and used in its place.
  assign line     = fwd_hit_r ? fwd_data_r : ram_q;
  assign near_raw = line[2*PIX_W-1:PIX_W];
  assign far_raw  = line[PIX_W-1:0];
  assign top      = s1_item.top_en ? far_raw : '0;
  assign mid      = s1_item.mid_en ? near_raw : '0;

  assign s1_take   = s1_valid && (!s1_item.emit || q_ready);
  assign ram_we    = s1_take;
  assign ram_waddr = s1_addr;
  assign ram_wdata = {s1_item.sample, near_raw};

  always_comb begin
    calc[0] = win_r[1];
    calc[1] = win_r[2];
    calc[3] = win_r[4];
    calc[4] = win_r[5];
    calc[6] = win_r[7];
    calc[7] = win_r[8];
    if (s1_item.col0) begin
      // Past the right edge of the previous row: pad with zeros.
      calc[2] = '0;
      calc[5] = '0;
      calc[8] = '0;
      win_nxt    = '0;
      win_nxt[2] = top;
      win_nxt[5] = mid;
      win_nxt[8] = s1_item.sample;
    end else begin
      calc[2] = top;
      calc[5] = mid;
      calc[8] = s1_item.sample;
      win_nxt = calc;
    end
    for (int k = 0; k < 9; k++) begin
      pr[k] = calc[k][3*CH_W-1:2*CH_W];
      pg[k] = calc[k][2*CH_W-1:CH_W];
      pb[k] = calc[k][CH_W-1:0];
    end
  end

  always_comb begin
    q_push          = s1_take && s1_item.emit;
    q_data.gx_red   = grad_x(pr);
    q_data.gy_red   = grad_y(pr);
    q_data.gx_green = grad_x(pg);
    q_data.gy_green = grad_y(pg);
    q_data.gx_blue  = grad_x(pb);
    q_data.gy_blue  = grad_y(pb);
    q_data.last     = s1_item.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (s1_take) begin
        win_r <= win_nxt;
      end
      if (rd_en) begin
        fwd_hit_r <= ram_we && (ram_waddr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= ram_wdata;
    end
  end

endmodule

// ===== sv/sem_queue.sv =====
// Short FIFO of gradient records between the window stage and the back end.
// Depends on sem_pkg for the record type and depth.
module sem_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           push_ready,
  input  sem_pkg::grad_t push_data,
  output logic           head_valid,
  input  logic           pop,
  output sem_pkg::grad_t head
);
  import sem_pkg::*;

  grad_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = count_r != (QAW+1)'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + (QAW+1)'(1);
      2'b01:   count_nxt = count_r - (QAW+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/sem_back.sv =====
// Back end: magnitude, halving and saturation per channel, then the output register.
// Depends on sem_pkg; drains the gradient queue.
module sem_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     head_valid,
  input  sem_pkg::grad_t           head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [sem_pkg::CH_W-1:0] out_red,
  output logic [sem_pkg::CH_W-1:0] out_green,
  output logic [sem_pkg::CH_W-1:0] out_blue,
  output logic                     out_last
);
  import sem_pkg::*;

  logic            out_valid_r;
  logic [CH_W-1:0] red_r, green_r, blue_r;
  logic            last_r;

  assign pop = head_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      red_r   <= half_mag(head.gx_red, head.gy_red);
      green_r <= half_mag(head.gx_green, head.gy_green);
      blue_r  <= half_mag(head.gx_blue, head.gy_blue);
      last_r  <= head.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_last  = last_r;

endmodule
